@@ hdl/hvn_pkg.sv @@
// ----------------------------------------------------------------------------
// hvn_pkg: shared definitions for the height-field vertex normal block
// Widths, fixed-point constants and payload types used by every module.
// ----------------------------------------------------------------------------
package hvn_pkg;

  // Height samples are signed Q3.(HEIGHT_WIDTH-4).
  localparam int HEIGHT_WIDTH = 16;
  localparam int FRAC_BITS    = HEIGHT_WIDTH - 4;

  // Vector components entering a normaliser: wide enough for a height
  // difference and for the sum of six unit normals.
  localparam int VEC_W = (HEIGHT_WIDTH + 1 > 18) ? HEIGHT_WIDTH + 1 : 18;
  localparam int MAG_W = VEC_W;
  localparam int SH_W  = $clog2(MAG_W) + 1;

  // Normaliser internals.
  localparam int Q_W        = 15;           // magnitude of a Q1.14 result
  localparam int OUT_W      = 16;           // signed Q1.14 result
  localparam int SQ_W       = 2 * Q_W;      // square of a reduced magnitude
  localparam int LEN_W      = SQ_W + 2;     // sum of three squares
  localparam int ACC_W      = 68;           // search accumulators
  localparam int SRCH_STEPS = Q_W;          // one result bit per stage
  localparam int SQ_SHIFT   = 30;           // scale of the compared square

  localparam int N_TRI = 6;

  // Stream payload widths.
  localparam int IN_DATA_W  = ((7 * HEIGHT_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Edge flag bit positions.
  localparam int FLAG_TOP    = 0;
  localparam int FLAG_BOTTOM = 1;
  localparam int FLAG_LEFT   = 2;
  localparam int FLAG_RIGHT  = 3;
  localparam int FLAG_W      = 4;

  // Vector component indexes.
  localparam int CMP_X = 0;
  localparam int CMP_Y = 1;
  localparam int CMP_Z = 2;

  typedef logic signed [HEIGHT_WIDTH-1:0] height_t;
  typedef logic signed [VEC_W-1:0]        vec_t;
  typedef logic signed [OUT_W-1:0]        unit_t;

endpackage

@@ hdl/hvn_unitize.sv @@
// ----------------------------------------------------------------------------
// hvn_unitize: pipelined vector normaliser
// Turns a signed 3-vector into a unit vector in Q1.14, each component being
// round(|c| * 16384 / sqrt(L)) with its sign restored. The result bits are
// found one per stage by an incremental square-and-compare search.
// ----------------------------------------------------------------------------
module hvn_unitize
  import hvn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ce,
  input  logic  in_valid,
  input  logic  in_tag,
  input  vec_t  in_vec [3],
  output logic  out_valid,
  output logic  out_tag,
  output unit_t out_vec [3]
);

  // Search state carried from stage to stage.
  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic [2:0][SQ_W-1:0]      sq;
    logic [2:0][ACC_W-1:0]     dsq;   // (2q-1)^2 * L
    logic [2:0][ACC_W-1:0]     dl;    // (2q-1) * L
    logic [2:0][Q_W-1:0]       q;
    logic [2:0]                neg;
    logic                      zero;
    logic                      tag;
  } srch_t;

  logic [MAG_W-1:0] mag1_r [3];
  logic [2:0]       neg1_r;
  logic             v1_r, tag1_r;

  logic [Q_W-1:0]   mag2_r [3];
  logic [2:0]       neg2_r;
  logic             v2_r, tag2_r;

  logic [SQ_W-1:0]  sq3_r [3];
  logic [2:0]       neg3_r;
  logic             v3_r, tag3_r;

  logic [MAG_W-1:0] top_mag;
  logic [SH_W-1:0]  sh;
  logic [LEN_W-1:0] len;
  srch_t            st_in;

  srch_t            st_r [SRCH_STEPS+1];
  srch_t            st_nxt [SRCH_STEPS];
  logic [SRCH_STEPS:0] sv_r;

  unit_t            res_r [3];
  logic             vo_r, tago_r;

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      sv_r <= '0;
      vo_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sv_r <= {sv_r[SRCH_STEPS-1:0], v3_r};
      vo_r <= sv_r[SRCH_STEPS];
    end
  end

  // Largest magnitude and the right shift that brings it below 2^15.
  always_comb begin
    top_mag = mag1_r[0];
    if (mag1_r[1] > top_mag) top_mag = mag1_r[1];
    if (mag1_r[2] > top_mag) top_mag = mag1_r[2];
    sh = '0;
    for (int i = Q_W; i < MAG_W; i++) begin
      if (top_mag[i]) sh = SH_W'(i - Q_W + 1);
    end
  end

  // Squared length and the starting point of the search (q = 0).
  always_comb begin
    len = LEN_W'(sq3_r[0]) + LEN_W'(sq3_r[1]) + LEN_W'(sq3_r[2]);
    st_in      = '0;
    st_in.len  = len;
    st_in.neg  = neg3_r;
    st_in.zero = (len == '0);
    st_in.tag  = tag3_r;
    for (int k = 0; k < 3; k++) begin
      st_in.sq[k]  = sq3_r[k];
      st_in.dsq[k] = ACC_W'(len);
      st_in.dl[k]  = ACC_W'(0) - ACC_W'(len);
    end
  end

  // Magnitude, reduction and squaring stages.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        neg1_r[k] <= in_vec[k][VEC_W-1];
        mag1_r[k] <= in_vec[k][VEC_W-1] ? MAG_W'(-in_vec[k]) : MAG_W'(in_vec[k]);
        mag2_r[k] <= Q_W'(mag1_r[k] >> sh);
        sq3_r[k]  <= SQ_W'(mag2_r[k]) * SQ_W'(mag2_r[k]);
      end
      tag1_r <= in_tag;
      neg2_r <= neg1_r;
      tag2_r <= tag1_r;
      neg3_r <= neg2_r;
      tag3_r <= tag2_r;
      st_r[0] <= st_in;
    end
  end

  // One result bit per stage, most significant first.
  for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
    localparam int BIT = Q_W - 1 - j;
    logic signed [ACC_W-1:0] l_ext;
    logic signed [ACC_W-1:0] d_new [3];
    logic signed [ACC_W-1:0] e_new [3];
    logic signed [ACC_W-1:0] r_ext [3];

    always_comb begin
      st_nxt[j] = st_r[j];
      l_ext = $signed({{(ACC_W-LEN_W){1'b0}}, st_r[j].len});
      for (int k = 0; k < 3; k++) begin
        d_new[k] = $signed(st_r[j].dsq[k]) + ($signed(st_r[j].dl[k]) <<< (BIT + 2))
                   + (l_ext <<< (2 * BIT + 2));
        e_new[k] = $signed(st_r[j].dl[k]) + (l_ext <<< (BIT + 1));
        r_ext[k] = $signed({{(ACC_W-SQ_W-SQ_SHIFT){1'b0}}, st_r[j].sq[k],
                            {SQ_SHIFT{1'b0}}});
        if (d_new[k] <= r_ext[k]) begin
          st_nxt[j].dsq[k]    = d_new[k];
          st_nxt[j].dl[k]     = e_new[k];
          st_nxt[j].q[k][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[j+1] <= st_nxt[j];
      end
    end
  end

  // Restore the signs; a zero vector stays zero.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        if (st_r[SRCH_STEPS].zero) begin
          res_r[k] <= '0;
        end else if (st_r[SRCH_STEPS].neg[k]) begin
          res_r[k] <= -$signed({1'b0, st_r[SRCH_STEPS].q[k]});
        end else begin
          res_r[k] <= $signed({1'b0, st_r[SRCH_STEPS].q[k]});
        end
      end
      tago_r <= st_r[SRCH_STEPS].tag;
    end
  end

  assign out_valid = vo_r;
  assign out_tag   = tago_r;
  assign out_vec   = res_r;

endmodule

@@ hdl/hvn_sum.sv @@
// ----------------------------------------------------------------------------
// hvn_sum: triangle normal accumulation
// Adds the six unit triangle normals and negates the z component of the sum.
// ----------------------------------------------------------------------------
module hvn_sum
  import hvn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ce,
  input  logic  in_valid,
  input  logic  in_tag,
  input  unit_t tri_vec [N_TRI][3],
  output logic  out_valid,
  output logic  out_tag,
  output vec_t  sum_vec [3]
);

  vec_t acc [3];
  vec_t sum_r [3];
  logic v_r, tag_r;

  // Component-wise sum of the six normals.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = '0;
      for (int t = 0; t < N_TRI; t++) begin
        acc[k] = acc[k] + VEC_W'(tri_vec[t][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ce) begin
      v_r <= in_valid;
    end
  end

  // The z axis points the other way in the output frame.
  always_ff @(posedge clk) begin
    if (ce) begin
      sum_r[CMP_X] <= acc[CMP_X];
      sum_r[CMP_Y] <= acc[CMP_Y];
      sum_r[CMP_Z] <= -acc[CMP_Z];
      tag_r        <= in_tag;
    end
  end

  assign out_valid = v_r;
  assign out_tag   = tag_r;
  assign sum_vec   = sum_r;

endmodule

@@ hdl/heightfield_vertex_normal.sv @@
// ----------------------------------------------------------------------------
// heightfield_vertex_normal: unit normal at one vertex of a height grid
// Input beats carry the centre height, six neighbour heights and the grid
// edge flags; output beats carry the Q1.14 unit normal and a flag that is set
// when no triangle touches the vertex (the normal is then zero).
//
// One input beat gives exactly one output beat, in order. The block takes a
// new beat every cycle while the skid register is empty. The path is an input
// register, a 20-stage normaliser for the six triangle normals (run as six
// parallel lanes), one summing stage and a second 20-stage normaliser. Each
// normaliser spends 15 of its stages on a one-bit-per-stage square-and-compare
// search, which sets the depth.
// A stall on the output side parks the last result in a skid register; while
// it is full the pipeline freezes and in_tready is low, so nothing is lost or
// repeated. Reset empties the pipeline; the block holds no other state.
// ----------------------------------------------------------------------------
module heightfield_vertex_normal
  import hvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // h_center, h_north, h_northeast, h_west, h_east, h_southwest, h_south
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // edge_flags
  input  logic [FLAG_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // no_triangles
  output logic                  out_tuser
);

  localparam vec_t ONE = vec_t'(1) <<< FRAC_BITS;

  height_t           h_r [7];
  logic [FLAG_W-1:0] flags_r;
  logic              v0_r;
  logic              ce;

  vec_t  hx [7];
  vec_t  tri_in [N_TRI][3];
  logic  no_tri;
  unit_t tri_out [N_TRI][3];
  logic  tri_valid, tri_tag;

  vec_t  sum_vec [3];
  logic  sum_valid, sum_tag;

  unit_t fin_vec [3];
  logic  fin_valid, fin_tag;

  logic [OUT_DATA_W-1:0] p_data;
  logic [OUT_DATA_W-1:0] skid_data_r;
  logic                  skid_tag_r;
  logic                  skid_v_r;

  // The pipeline moves whenever the skid register is free.
  assign ce        = !skid_v_r;
  assign in_tready = !skid_v_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 7; i++) begin
        h_r[i] <= in_tdata[i*HEIGHT_WIDTH +: HEIGHT_WIDTH];
      end
      flags_r <= in_tuser;
    end
  end

  // Triangle normals; a triangle beyond the grid edge is a zero vector.
  always_comb begin
    logic nw_ok, ne_ok, se_ok, sw_ok;
    for (int i = 0; i < 7; i++) begin
      hx[i] = VEC_W'(h_r[i]);
    end
    nw_ok = !flags_r[FLAG_TOP]    && !flags_r[FLAG_LEFT];
    ne_ok = !flags_r[FLAG_TOP]    && !flags_r[FLAG_RIGHT];
    se_ok = !flags_r[FLAG_BOTTOM] && !flags_r[FLAG_RIGHT];
    sw_ok = !flags_r[FLAG_BOTTOM] && !flags_r[FLAG_LEFT];
    no_tri = !(nw_ok || ne_ok || se_ok || sw_ok);
    // Order of hx: centre, north, northeast, west, east, southwest, south.
    tri_in[0] = '{hx[3] - hx[0], ONE, hx[1] - hx[0]};  // north-west down
    tri_in[1] = '{hx[1] - hx[2], ONE, hx[1] - hx[0]};  // north-east up
    tri_in[2] = '{hx[0] - hx[4], ONE, hx[2] - hx[4]};  // north-east down
    tri_in[3] = '{hx[0] - hx[4], ONE, hx[0] - hx[6]};  // south-east up
    tri_in[4] = '{hx[3] - hx[0], ONE, hx[3] - hx[5]};  // south-west up
    tri_in[5] = '{hx[5] - hx[6], ONE, hx[0] - hx[6]};  // south-west down
    if (!nw_ok) tri_in[0] = '{'0, '0, '0};
    if (!ne_ok) tri_in[1] = '{'0, '0, '0};
    if (!ne_ok) tri_in[2] = '{'0, '0, '0};
    if (!se_ok) tri_in[3] = '{'0, '0, '0};
    if (!sw_ok) tri_in[4] = '{'0, '0, '0};
    if (!sw_ok) tri_in[5] = '{'0, '0, '0};
  end

  // Six parallel normaliser lanes; lane 0 carries the no-triangle flag.
  hvn_unitize u_tri0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v0_r),
    .in_tag    (no_tri),
    .in_vec    (tri_in[0]),
    .out_valid (tri_valid),
    .out_tag   (tri_tag),
    .out_vec   (tri_out[0])
  );

  for (genvar t = 1; t < N_TRI; t++) begin : g_tri
    hvn_unitize u_tri (
      .clk       (clk),
      .rst_n     (rst_n),
      .ce        (ce),
      .in_valid  (v0_r),
      .in_tag    (1'b0),
      .in_vec    (tri_in[t]),
      .out_valid (),
      .out_tag   (),
      .out_vec   (tri_out[t])
    );
  end

  // Sum of the unit normals.
  hvn_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (tri_valid),
    .in_tag    (tri_tag),
    .tri_vec   (tri_out),
    .out_valid (sum_valid),
    .out_tag   (sum_tag),
    .sum_vec   (sum_vec)
  );

  // Final normalisation; a zero sum gives a zero normal.
  hvn_unitize u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (sum_valid),
    .in_tag    (sum_tag),
    .in_vec    (sum_vec),
    .out_valid (fin_valid),
    .out_tag   (fin_tag),
    .out_vec   (fin_vec)
  );

  assign p_data = OUT_DATA_W'({fin_vec[CMP_Z], fin_vec[CMP_Y], fin_vec[CMP_X]});

  // Skid register: catches the pipeline head when the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) skid_v_r <= 1'b0;
    end else if (fin_valid && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_data_r <= p_data;
      skid_tag_r  <= fin_tag;
    end
  end

  // Output beat comes from the skid register first.
  assign out_tvalid = skid_v_r || fin_valid;
  assign out_tdata  = skid_v_r ? skid_data_r : p_data;
  assign out_tuser  = skid_v_r ? skid_tag_r : fin_tag;

endmodule

@@ tb/hvn_checker.sv @@
// ----------------------------------------------------------------------------
// hvn_checker: predictor and scoreboard for the vertex normal block
// Watches both stream channels, computes the expected unit normal for every
// accepted input beat and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvn_checker
  import hvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [FLAG_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    unit_t nx;
    unit_t ny;
    unit_t nz;
    logic  none;
  } normal_beat_t;

  normal_beat_t expected_normals[$];

  typedef longint vec3_t [3];

  // a*b <= c with a 128-bit product.
  function automatic bit mul_le(longint a, longint b, longint c);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p <= 128'(c);
  endfunction

  // Scale a vector to Q1.14 length, rounding each component to nearest.
  function automatic vec3_t make_unit(vec3_t v);
    longint mag[3];
    longint top;
    longint len2;
    longint rhs;
    longint q;
    longint t;
    longint d;
    vec3_t  r;
    top = 0;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (v[k] < 0) ? -v[k] : v[k];
      if (mag[k] > top) top = mag[k];
    end
    while (top >= 32768) begin
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >>> 1;
      top = top >>> 1;
    end
    for (int k = 0; k < 3; k++) len2 += mag[k] * mag[k];
    for (int k = 0; k < 3; k++) begin
      r[k] = 0;
      if (len2 != 0) begin
        rhs = (mag[k] * mag[k]) << 30;
        q = 0;
        // The product d^2 * len2 can exceed 2^61, so it is formed in 128 bits.
        for (int b = 14; b >= 0; b--) begin
          t = q | (longint'(1) << b);
          d = 2 * t - 1;
          if (t <= 16384) begin
            if (mul_le(d * d, len2, rhs)) q = t;
          end
        end
        if (q == 0 && mul_le(32767 * 32767, len2, rhs)) q = 16384;
        r[k] = (v[k] < 0) ? -q : q;
      end
    end
    return r;
  endfunction

  function automatic normal_beat_t predict_normal(logic [IN_DATA_W-1:0] d,
                                                  logic [FLAG_W-1:0] f);
    longint c, n, ne, w, e, sw, s, one;
    vec3_t acc, u, tri_v;
    int tris;
    normal_beat_t r;
    c  = height_t'(d[0*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    n  = height_t'(d[1*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    ne = height_t'(d[2*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    w  = height_t'(d[3*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    e  = height_t'(d[4*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    sw = height_t'(d[5*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    s  = height_t'(d[6*HEIGHT_WIDTH +: HEIGHT_WIDTH]);
    one = longint'(1) << FRAC_BITS;
    acc = '{0, 0, 0};
    tris = 0;
    for (int i = 0; i < N_TRI; i++) begin
      bit used;
      case (i)
        0: begin used = !f[FLAG_TOP] && !f[FLAG_LEFT];     tri_v = '{w - c, one, n - c};  end
        1: begin used = !f[FLAG_TOP] && !f[FLAG_RIGHT];    tri_v = '{n - ne, one, n - c}; end
        2: begin used = !f[FLAG_TOP] && !f[FLAG_RIGHT];    tri_v = '{c - e, one, ne - e}; end
        3: begin used = !f[FLAG_BOTTOM] && !f[FLAG_RIGHT]; tri_v = '{c - e, one, c - s};  end
        4: begin used = !f[FLAG_BOTTOM] && !f[FLAG_LEFT];  tri_v = '{w - c, one, w - sw}; end
        default: begin
          used = !f[FLAG_BOTTOM] && !f[FLAG_LEFT];
          tri_v = '{sw - s, one, c - s};
        end
      endcase
      if (used) begin
        u = make_unit(tri_v);
        for (int k = 0; k < 3; k++) acc[k] += u[k];
        tris++;
      end
    end
    u = '{0, 0, 0};
    if (tris > 0) begin
      acc[CMP_Z] = -acc[CMP_Z];
      u = make_unit(acc);
    end
    r.nx = unit_t'(u[CMP_X]);
    r.ny = unit_t'(u[CMP_Y]);
    r.nz = unit_t'(u[CMP_Z]);
    r.none = (tris == 0);
    return r;
  endfunction

  assign pending = expected_normals.size();

  // Predict on every input beat, check on every output beat.
  always @(posedge clk) begin
    normal_beat_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_normals.insert(expected_normals.size(),
                                predict_normal(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (expected_normals.size() == 0) begin
          $error("output beat with no expected normal waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_normals.pop_front();
          if (unit_t'(out_tdata[0 +: OUT_W]) !== want.nx ||
              unit_t'(out_tdata[OUT_W +: OUT_W]) !== want.ny ||
              unit_t'(out_tdata[2*OUT_W +: OUT_W]) !== want.nz ||
              out_tuser !== want.none) begin
            if (unit_t'(out_tdata[0 +: OUT_W]) !== want.nx)
              $error("normal_x expected %0d got %0d", want.nx,
                     unit_t'(out_tdata[0 +: OUT_W]));
            if (unit_t'(out_tdata[OUT_W +: OUT_W]) !== want.ny)
              $error("normal_y expected %0d got %0d", want.ny,
                     unit_t'(out_tdata[OUT_W +: OUT_W]));
            if (unit_t'(out_tdata[2*OUT_W +: OUT_W]) !== want.nz)
              $error("normal_z expected %0d got %0d", want.nz,
                     unit_t'(out_tdata[2*OUT_W +: OUT_W]));
            if (out_tuser !== want.none)
              $error("no_triangles expected %0d got %0d", want.none, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_heightfield_vertex_normal.sv @@
// ----------------------------------------------------------------------------
// tb_heightfield_vertex_normal: stimulus and verdict for the normal block
// Drives directed and random vertex beats through phases of sender gaps and
// receiver stalls, including one long hold-off; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heightfield_vertex_normal;
  import hvn_pkg::*;

  localparam int LATENCY    = 42;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BEATS = 1280;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FLAG_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  int                    fail_count;
  int                    pending;

  // Idling percentages per phase, and the long hold-off request.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  always #4 clk = ~clk;

  heightfield_vertex_normal u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  hvn_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stalls, or a long counted hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL heightfield_vertex_normal");
      $finish;
    end
  end

  function automatic logic [15:0] pick_height();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one vertex beat, holding it until accepted.
  task automatic send_vertex(logic [16*7-1:0] heights, logic [FLAG_W-1:0] flags);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(heights);
    in_tuser  <= flags;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // A smooth patch around a random base, as a real height map gives.
  task automatic send_random();
    logic [16*7-1:0] hs;
    int base;
    base = int'($urandom_range(8000)) - 4000;
    for (int i = 0; i < 7; i++) begin
      if ($urandom_range(3) == 0) hs[i*16 +: 16] = pick_height();
      else hs[i*16 +: 16] = 16'(base + int'($urandom_range(2000)) - 1000);
    end
    send_vertex(hs, FLAG_W'($urandom_range(15)));
  endtask

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flat, extremes, all edge combinations, single-row grids.
    send_vertex('0, 4'b0000);
    send_vertex({7{16'h7fff}}, 4'b0000);
    send_vertex({7{16'h8000}}, 4'b0000);
    send_vertex({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h7fff, 16'h8000}, 4'b0000);
    send_vertex({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000, 16'h7fff}, 4'b0000);
    for (int f = 0; f < 16; f++)
      send_vertex({16'h1000, 16'hf000, 16'h0800, 16'h0000, 16'h2000,
                   16'hffff, 16'h0001}, FLAG_W'(f));

    // Random phases: none, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 58) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 58) : 0;
      for (int i = 0; i < RANDOM_BEATS / 4; i++) begin
        // Long receiver hold-off while beats keep coming.
        if (ph == 0 && i == 50) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (200) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_random();
      end
    end
    in_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS heightfield_vertex_normal");
    end else begin
      $display("FAIL heightfield_vertex_normal");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/hvn_pkg.sv
hdl/hvn_unitize.sv
hdl/hvn_sum.sv
hdl/heightfield_vertex_normal.sv
tb/hvn_checker.sv
tb/tb_heightfield_vertex_normal.sv
